// File: rtl/core/tcprrt_pkg.sv
// Package for the TCP receive reorder tracker.
// Shared widths and the controller state type; no dependencies.
package tcprrt_pkg;

   localparam int SEQ_W  = 32;   // sequence number width
   localparam int SIZE_W = 16;   // segment size width
   localparam int ADV_W  = 7;    // advanced count width on the result
   localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1460;

   typedef enum logic [2:0] {
      ST_CLEAR,   // sweep the held-slot memory after reset
      ST_IDLE,    // wait for a segment
      ST_CHECK,   // compare with expected sequence and window bound
      ST_DIVS,    // slot divide for a later segment, then mark it
      ST_DIVE,    // slot divide for the new expected sequence
      ST_READ,    // read held bit of the expected slot
      ST_DRAIN,   // test held bit, clear it and advance
      ST_DONE     // hand the result to the output register
   } state_type;

endpackage

// File: rtl/core/tcp_receive_reorder_tracker.sv
// TCP receive reorder tracker: expected sequence plus held-slot bitmap memory.
// Depends on tcprrt_pkg and tcprrt_slot_div.
//
//   channel  ports                    dir  word
//   req      req_valid/req_ready      in   segment_seq
//   rsp      rsp_valid/rsp_ready      out  ack_number, in_order, segments_advanced,
//                                          window_overflow
//   csr      csr_valid/csr_ready      in   segment_size
//
// After reset the held-slot memory is swept, every slot cleared, before req_ready rises.
// One segment at a time, from acceptance to the result register: an older or dropped segment
// goes straight to it, a later in-window one takes a 32-step slot divide and then a mark, an
// in-order one a slot divide, then a read and drain step per held slot up to the drain limit
// and a new divide for each wrap of the expected sequence past 2^32 in the drain. req_ready
// returns in the cycle after the load; a waiting result only stalls the next one at its end.
module tcp_receive_reorder_tracker #(
   parameter int WINDOW_SEGMENTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tcprrt_pkg::SEQ_W-1:0]       req_segment_seq,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tcprrt_pkg::SEQ_W-1:0]       rsp_ack_number,
   output logic                               rsp_in_order,
   output logic [tcprrt_pkg::ADV_W-1:0]       rsp_segments_advanced,
   output logic                               rsp_window_overflow,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tcprrt_pkg::SIZE_W-1:0]      csr_segment_size
);

   localparam int SW = $clog2(WINDOW_SEGMENTS);
   localparam int AW = $clog2(WINDOW_SEGMENTS + 1);
   localparam int PW = tcprrt_pkg::SIZE_W + SW;
   localparam int QW = tcprrt_pkg::SEQ_W;

   tcprrt_pkg::state_type state_ff, state_in;

   logic [QW-1:0]                    seq_ff;
   logic [QW-1:0]                    exp_ff, exp_in;
   logic [tcprrt_pkg::SIZE_W-1:0]    size_ff;
   logic [PW-1:0]                    span_ff;
   logic [SW-1:0]                    slot_ff, slot_in;
   logic [SW-1:0]                    drn_ff, drn_in;
   logic [AW-1:0]                    adv_ff, adv_in;
   logic                             ino_ff, ino_in;
   logic                             ovf_ff, ovf_in;
   logic [SW-1:0]                    clr_ff;
   logic                             rd_ff;

   logic                             rsp_valid_ff;
   logic [QW-1:0]                    rsp_ack_ff;
   logic                             rsp_ino_ff;
   logic [tcprrt_pkg::ADV_W-1:0]     rsp_adv_ff;
   logic                             rsp_ovf_ff;
   logic                             rsp_load;

   logic [tcprrt_pkg::SIZE_W-1:0]    mss;
   logic [QW:0]                      exp_sum;
   logic [QW:0]                      bound;

   logic                             div_start;
   logic [QW-1:0]                    div_dividend;
   logic                             div_done;
   logic [SW-1:0]                    div_slot;

   logic                             mem_we;
   logic [SW-1:0]                    mem_wa;
   logic                             mem_wd;
   logic                             held_mem [WINDOW_SEGMENTS];

   // effective segment size, zero reads as one
   assign mss     = (size_ff == '0) ? tcprrt_pkg::SIZE_W'(1) : size_ff;
   assign exp_sum = {1'b0, exp_ff} + (QW+1)'(mss);
   assign bound   = {1'b0, exp_ff} + (QW+1)'(span_ff);

   // configuration register and window span
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= tcprrt_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_segment_size;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= PW'(mss) * PW'(WINDOW_SEGMENTS - 1);
   end

   tcprrt_slot_div #(
      .WINDOW (WINDOW_SEGMENTS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (mss),
      .done     (div_done),
      .slot     (div_slot)
   );

   // controller next state
   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      slot_in      = slot_ff;
      drn_in       = drn_ff;
      adv_in       = adv_ff;
      ino_in       = ino_ff;
      ovf_in       = ovf_ff;
      div_start    = 1'b0;
      div_dividend = seq_ff;
      mem_we       = 1'b0;
      mem_wa       = slot_ff;
      mem_wd       = 1'b0;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         tcprrt_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            if (clr_ff == SW'(WINDOW_SEGMENTS - 1)) begin
               state_in = tcprrt_pkg::ST_IDLE;
            end
         end
         tcprrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ino_in   = 1'b0;
               ovf_in   = 1'b0;
               adv_in   = '0;
               drn_in   = '0;
               state_in = tcprrt_pkg::ST_CHECK;
            end
         end
         tcprrt_pkg::ST_CHECK: begin
            if (seq_ff == exp_ff) begin
               ino_in       = 1'b1;
               adv_in       = AW'(1);
               exp_in       = exp_sum[QW-1:0];
               div_start    = 1'b1;
               div_dividend = exp_sum[QW-1:0];
               state_in     = tcprrt_pkg::ST_DIVE;
            end else if (seq_ff > exp_ff) begin
               if ({1'b0, seq_ff} > bound) begin
                  ovf_in   = 1'b1;
                  state_in = tcprrt_pkg::ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = tcprrt_pkg::ST_DIVS;
               end
            end else begin
               state_in = tcprrt_pkg::ST_DONE;
            end
         end
         tcprrt_pkg::ST_DIVS: begin
            if (div_done) begin
               mem_we   = 1'b1;
               mem_wa   = div_slot;
               mem_wd   = 1'b1;
               state_in = tcprrt_pkg::ST_DONE;
            end
         end
         tcprrt_pkg::ST_DIVE: begin
            if (div_done) begin
               slot_in  = div_slot;
               state_in = tcprrt_pkg::ST_READ;
            end
         end
         tcprrt_pkg::ST_READ: begin
            // memory address is slot_ff; data lands in rd_ff
            if (drn_ff == SW'(WINDOW_SEGMENTS - 1)) begin
               state_in = tcprrt_pkg::ST_DONE;
            end else begin
               state_in = tcprrt_pkg::ST_DRAIN;
            end
         end
         tcprrt_pkg::ST_DRAIN: begin
            if (!rd_ff) begin
               state_in = tcprrt_pkg::ST_DONE;
            end else begin
               mem_we = 1'b1;
               mem_wa = slot_ff;
               drn_in = drn_ff + 1'b1;
               adv_in = adv_ff + 1'b1;
               exp_in = exp_sum[QW-1:0];
               if (exp_sum[QW]) begin
                  // sequence wrapped: slot no longer follows by one
                  div_start    = 1'b1;
                  div_dividend = exp_sum[QW-1:0];
                  state_in     = tcprrt_pkg::ST_DIVE;
               end else begin
                  slot_in  = (slot_ff == SW'(WINDOW_SEGMENTS - 1)) ? '0 : slot_ff + 1'b1;
                  state_in = tcprrt_pkg::ST_READ;
               end
            end
         end
         tcprrt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = tcprrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcprrt_pkg::ST_IDLE;
         end
      endcase
   end

   // controller registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcprrt_pkg::ST_CLEAR;
         exp_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         if (state_ff == tcprrt_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      drn_ff  <= drn_in;
      adv_ff  <= adv_in;
      ino_ff  <= ino_in;
      ovf_ff  <= ovf_in;
      if (req_valid && req_ready) begin
         seq_ff <= req_segment_seq;
      end
   end

   // held-slot memory, one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= held_mem[slot_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ack_ff <= exp_ff - QW'(mss);
         rsp_ino_ff <= ino_ff;
         rsp_adv_ff <= tcprrt_pkg::ADV_W'(adv_ff);
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ack_number        = rsp_ack_ff;
   assign rsp_in_order          = rsp_ino_ff;
   assign rsp_segments_advanced = rsp_adv_ff;
   assign rsp_window_overflow   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_in_order && rsp_window_overflow))
      else $error("in_order and window_overflow both set");

   a_in_order_advances: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_order) |-> (rsp_segments_advanced != '0))
      else $error("in-order segment did not advance");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == tcprrt_pkg::ST_DIVS || state_ff == tcprrt_pkg::ST_DIVE))
      else $error("divider finished outside a divide state");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcprrt_pkg::ST_CLEAR) |-> !req_ready)
      else $error("segment accepted during memory sweep");
`endif

endmodule

// File: rtl/core/tcprrt_slot_div.sv
// Iterative slot divider: slot = (dividend / divisor) mod WINDOW.
// One quotient bit per cycle, quotient kept reduced modulo the window.
// Depends on tcprrt_pkg.
module tcprrt_slot_div #(
   parameter int WINDOW = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tcprrt_pkg::SEQ_W-1:0]       dividend,
   input  logic [tcprrt_pkg::SIZE_W-1:0]      divisor,
   output logic                               done,
   output logic [$clog2(WINDOW)-1:0]          slot
);

   localparam int SW = $clog2(WINDOW);
   localparam int CW = $clog2(tcprrt_pkg::SEQ_W);

   logic                             run_ff;
   logic                             done_ff;
   logic [CW-1:0]                    cnt_ff;
   logic [tcprrt_pkg::SEQ_W-1:0]     dvd_ff;
   logic [tcprrt_pkg::SIZE_W-1:0]    rem_ff;
   logic [SW-1:0]                    qm_ff;

   logic [tcprrt_pkg::SIZE_W:0]      rem_sh;
   logic                             qbit;
   logic [tcprrt_pkg::SIZE_W-1:0]    rem_in;
   logic [SW:0]                      q2;
   logic [SW-1:0]                    qm_in;

   // one restoring step, quotient folded modulo the window
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[tcprrt_pkg::SEQ_W-1]};
      qbit   = (rem_sh >= {1'b0, divisor});
      if (qbit) begin
         rem_in = tcprrt_pkg::SIZE_W'(rem_sh - {1'b0, divisor});
      end else begin
         rem_in = rem_sh[tcprrt_pkg::SIZE_W-1:0];
      end
      q2 = {qm_ff, qbit};
      if (q2 >= (SW+1)'(WINDOW)) begin
         qm_in = SW'(q2 - (SW+1)'(WINDOW));
      end else begin
         qm_in = q2[SW-1:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(tcprrt_pkg::SEQ_W-1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         qm_ff  <= '0;
      end else if (run_ff) begin
         dvd_ff <= {dvd_ff[tcprrt_pkg::SEQ_W-2:0], 1'b0};
         rem_ff <= rem_in;
         qm_ff  <= qm_in;
      end
   end

   assign done = done_ff;
   assign slot = qm_ff;

endmodule

// File: tb/tb_tcp_receive_reorder_tracker.sv
// Self-checking testbench for tcp_receive_reorder_tracker: segment stream with random
// reordering, holes and stray segments, checked against an in-bench ack predictor.
// Depends on tcprrt_pkg and the tracker RTL only.
module tb_tcp_receive_reorder_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW      = 64;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_AT     = 300;   // accepted segments before the long receiver stall
   localparam int HOLD_CYCLES = 500;
   localparam int TAIL_CYCLES = 250;
   localparam int PRINT_MAX   = 20;

   // one result word, packed in port order
   typedef struct packed {
      logic [tcprrt_pkg::SEQ_W-1:0] ack;
      logic                         in_order;
      logic [tcprrt_pkg::ADV_W-1:0] advanced;
      logic                         overflow;
   } ack_word_type;

   // Ack predictor: own copy of expected sequence, held bitmap and segment size
   class ack_scoreboard_type;
      logic [tcprrt_pkg::SEQ_W-1:0]  next_seq;
      logic [WINDOW-1:0]             held_map;
      logic [tcprrt_pkg::SIZE_W-1:0] seg_bytes;
      ack_word_type                  waiting[$];
      int                            errors;

      function new();
         next_seq  = '0;
         held_map  = '0;
         seg_bytes = tcprrt_pkg::SIZE_RESET;
         errors    = 0;
      endfunction

      // a size of zero steps by one byte
      function logic [tcprrt_pkg::SEQ_W-1:0] step_bytes();
         return (seg_bytes == '0) ? 32'd1 : {16'd0, seg_bytes};
      endfunction

      function int slot_index(logic [tcprrt_pkg::SEQ_W-1:0] seq);
         return int'((seq / step_bytes()) % 32'(WINDOW));
      endfunction

      // accepted segment: update state, queue the ack it must produce
      function void note_segment(logic [tcprrt_pkg::SEQ_W-1:0] seq);
         ack_word_type                 w;
         logic [tcprrt_pkg::SEQ_W-1:0] step;
         logic [63:0]                  bound;
         int                           drained;
         step = step_bytes();
         w    = '0;
         if (seq == next_seq) begin
            w.in_order = 1'b1;
            next_seq   = next_seq + step;
            drained    = 0;
            // drain consecutive held slots, never more than WINDOW-1
            while (drained < WINDOW - 1 && held_map[slot_index(next_seq)]) begin
               held_map[slot_index(next_seq)] = 1'b0;
               next_seq = next_seq + step;
               drained++;
            end
            w.advanced = tcprrt_pkg::ADV_W'(drained + 1);
         end else if (seq > next_seq) begin
            // window bound in 64 bits, no wrap handling
            bound = {32'd0, next_seq} + 64'(WINDOW - 1) * {32'd0, step};
            if ({32'd0, seq} > bound)
               w.overflow = 1'b1;
            else
               held_map[slot_index(seq)] = 1'b1;
         end
         w.ack = next_seq - step;
         waiting.push_back(w);
      endfunction

      task flag_mismatch(string what);
         if (errors < PRINT_MAX)
            $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_ack(ack_word_type got);
         ack_word_type want;
         if (waiting.size() == 0) begin
            flag_mismatch($sformatf("ack %h with no segment pending", got.ack));
            return;
         end
         want = waiting.pop_front();
         if (got.ack !== want.ack)
            flag_mismatch($sformatf("ack_number %h, want %h", got.ack, want.ack));
         if (got.in_order !== want.in_order)
            flag_mismatch($sformatf("in_order %b, want %b", got.in_order, want.in_order));
         if (got.advanced !== want.advanced)
            flag_mismatch($sformatf("segments_advanced %0d, want %0d",
                                    got.advanced, want.advanced));
         if (got.overflow !== want.overflow)
            flag_mismatch($sformatf("window_overflow %b, want %b",
                                    got.overflow, want.overflow));
      endtask

      task close_out();
         while (waiting.size() != 0) begin
            flag_mismatch($sformatf("ack %h never arrived", waiting[0].ack));
            void'(waiting.pop_front());
         end
      endtask
   endclass

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [tcprrt_pkg::SEQ_W-1:0]  req_segment_seq  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic [tcprrt_pkg::SEQ_W-1:0]  rsp_ack_number;
   logic                          rsp_in_order;
   logic [tcprrt_pkg::ADV_W-1:0]  rsp_segments_advanced;
   logic                          rsp_window_overflow;
   logic                          csr_valid        = 1'b0;
   logic                          csr_ready;
   logic [tcprrt_pkg::SIZE_W-1:0] csr_segment_size = '0;

   ack_scoreboard_type sb;
   int                 sent_count  = 0;
   int                 cycle_count = 0;
   int                 rx_wait     = 0;
   logic               calm        = 1'b0;   // no idling on either side
   logic               hold_rsp    = 1'b0;

   tcp_receive_reorder_tracker #(
      .WINDOW_SEGMENTS(WINDOW)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_segment_seq       (req_segment_seq),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_ack_number        (rsp_ack_number),
      .rsp_in_order          (rsp_in_order),
      .rsp_segments_advanced (rsp_segments_advanced),
      .rsp_window_overflow   (rsp_window_overflow),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_segment_size      (csr_segment_size)
   );

   always #6 clock = ~clock;

   // idle length: mostly none, some short, a few long
   function int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // offer one segment word, hold it until accepted
   task send_segment(input logic [tcprrt_pkg::SEQ_W-1:0] seq);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_segment_seq <= seq;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_segment(seq);
      sent_count++;
   endtask

   // stop offering and wait for every pending ack
   task settle();
      req_valid <= 1'b0;
      while (sb.waiting.size() != 0) @(posedge clock);
   endtask

   task write_size(input logic [tcprrt_pkg::SIZE_W-1:0] value);
      settle();
      csr_valid        <= 1'b1;
      csr_segment_size <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.seg_bytes = value;
      csr_valid <= 1'b0;
   endtask

   // mark every free slot of the window with a later segment
   task fill_window();
      logic [tcprrt_pkg::SEQ_W-1:0] seq;
      int                           j;
      for (j = 1; j < WINDOW; j++) begin
         seq = sb.next_seq + j * sb.step_bytes();
         if (!sb.held_map[sb.slot_index(seq)])
            send_segment(seq);
      end
   endtask

   // a run of consecutive segments from the expected one, shuffled two times in three, with holes and dups
   task send_burst(input int n);
      int                           order[WINDOW];
      int                           i;
      int                           j;
      int                           t;
      logic [tcprrt_pkg::SEQ_W-1:0] base;
      logic [tcprrt_pkg::SEQ_W-1:0] step;
      base = sb.next_seq;
      step = sb.step_bytes();
      for (i = 0; i < n; i++)
         order[i] = i;
      if ($urandom_range(2) != 0) begin
         for (i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
         end
      end
      for (i = 0; i < n; i++) begin
         if ($urandom_range(19) != 0) begin
            send_segment(base + order[i] * step);
            if ($urandom_range(15) == 0)
               send_segment(base + order[i] * step);
         end
      end
   endtask

   // stray segments: older, past the window, at the bound, unaligned, fully random
   task send_noise();
      logic [tcprrt_pkg::SEQ_W-1:0] seq;
      logic [tcprrt_pkg::SEQ_W-1:0] step;
      logic [63:0]                  far;
      step = sb.step_bytes();
      case ($urandom_range(4))
         0: seq = (sb.next_seq == '0) ? '0 : $urandom_range(sb.next_seq - 1);
         1: begin
            far = {32'd0, sb.next_seq} + 64'(WINDOW - 1) * {32'd0, step} + 64'd1 +
                  64'($urandom_range(3 * step));
            seq = (far > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : far[31:0];
         end
         2: seq = $urandom();
         3: seq = sb.next_seq + (WINDOW - 1) * step;
         default: seq = sb.next_seq + $urandom_range((WINDOW - 1) * step);
      endcase
      send_segment(seq);
   endtask

   task run_random(input int count);
      int target;
      target = sent_count + count;
      while (sent_count < target) begin
         if ($urandom_range(9) < 8)
            send_burst(($urandom_range(99) < 80) ? $urandom_range(8, 1)
                                                 : $urandom_range(WINDOW, 9));
         else
            send_noise();
      end
   endtask

   // receiver: random stalls, or a long hold-off while hold_rsp is up
   always @(posedge clock) begin : rx_side
      int gap;
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rx_wait > 0) begin
         rsp_ready <= 1'b0;
         rx_wait   <= rx_wait - 1;
      end else begin
         gap       = pick_gap();
         rsp_ready <= (gap == 0);
         rx_wait   <= (gap > 0) ? gap - 1 : 0;
      end
   end

   // long receiver hold-off, counted here, while the sender keeps offering
   initial begin
      wait (sent_count >= HOLD_AT);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_ack({rsp_ack_number, rsp_in_order, rsp_segments_advanced,
                       rsp_window_overflow});
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[tcp_receive_reorder_tracker] ERROR");
      $finish;
   end

   initial begin
      logic [tcprrt_pkg::SEQ_W-1:0]  e;
      logic [tcprrt_pkg::SEQ_W-1:0]  s;
      logic [tcprrt_pkg::SIZE_W-1:0] alt;
      logic [tcprrt_pkg::SIZE_W-1:0] sizes[8];
      int                            i;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset size: ack below zero, bound edges, unaligned, older, drain of one
      s = sb.step_bytes();
      send_segment(32'hFFFF_FFFF);
      send_segment(32'd0);
      e = sb.next_seq;
      send_segment(e + (WINDOW - 1) * s);
      send_segment(e + (WINDOW - 1) * s + 1);
      send_segment(e + 2 * s);
      send_segment(e + 2 * s + 100);
      send_segment(32'd0);
      send_segment(e - 1);
      send_segment(e);
      send_segment(e + s);

      // directed, zero size steps by one byte
      write_size(16'd0);
      e = sb.next_seq;
      send_segment(e + 1);
      send_segment(e + WINDOW - 1);
      send_segment(e + WINDOW);
      send_segment(e);
      send_segment(e - 1);

      // directed, largest size
      write_size(16'hFFFF);
      e = sb.next_seq;
      send_segment(e);
      send_segment(sb.next_seq + (WINDOW - 1) * sb.step_bytes());

      // drain limit: all slots held, including the one under the expected segment
      write_size(16'd1);
      fill_window();
      alt = 16'd2;
      while (alt < 16'd9 && (sb.next_seq / alt) % WINDOW == sb.next_seq % WINDOW)
         alt++;
      write_size(alt);
      fill_window();
      send_segment(sb.next_seq);

      // random phases over several sizes, extremes among them
      sizes = '{16'd0, 16'hFFFF, 16'd2, 16'd7, 16'd536, 16'd1, 16'd1460, 16'd3};
      sizes[5] = 16'($urandom_range(16'hFFFF, 1));
      sizes[7] = 16'($urandom_range(300, 3));
      for (i = 0; i < 8; i++) begin
         write_size(sizes[i]);
         calm <= (i == 2);
         run_random(85);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0)
         $display("[tcp_receive_reorder_tracker] OK");
      else
         $display("[tcp_receive_reorder_tracker] ERROR");
      $finish;
   end

endmodule
